// ----- rtl/tcpop_pkg.sv -----
// Types and constants for the TCP options walker.
// Holds the transfer payload structs, the parse phase, option kinds and status codes.
// No dependencies.
package tcpop_pkg;

   typedef struct packed {
      logic [7:0]  opt_byte;
      logic [5:0]  area_len;
      logic [31:0] sack_base;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] mss_value;
      logic [31:0] sack_left;
      logic [31:0] sack_right;
      logic [2:0]  stop_status;
      logic        result_last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      PH_KIND,
      PH_LEN,
      PH_DATA,
      PH_STOP
   } phase_type;

   localparam logic [1:0] RK_MSS  = 2'd0;
   localparam logic [1:0] RK_SACK = 2'd1;
   localparam logic [1:0] RK_END  = 2'd2;

   localparam logic [2:0] ST_CONSUMED  = 3'd0;
   localparam logic [2:0] ST_EOL       = 3'd1;
   localparam logic [2:0] ST_UNKNOWN   = 3'd2;
   localparam logic [2:0] ST_NO_LEN    = 3'd3;
   localparam logic [2:0] ST_BAD_FIXED = 3'd4;
   localparam logic [2:0] ST_OVERRUN   = 3'd5;
   localparam logic [2:0] ST_BAD_SACK  = 3'd6;

   localparam logic [7:0] KIND_EOL     = 8'd0;
   localparam logic [7:0] KIND_NOP     = 8'd1;
   localparam logic [7:0] KIND_MSS     = 8'd2;
   localparam logic [7:0] KIND_WSCALE  = 8'd3;
   localparam logic [7:0] KIND_SACK_OK = 8'd4;
   localparam logic [7:0] KIND_SACK    = 8'd5;
   localparam logic [7:0] KIND_TSTAMP  = 8'd8;

   function automatic logic [7:0] fixed_len_of(input logic [7:0] kind);
      logic [7:0] len;
      case (kind)
         KIND_MSS:     len = 8'd4;
         KIND_WSCALE:  len = 8'd3;
         KIND_SACK_OK: len = 8'd2;
         KIND_TSTAMP:  len = 8'd10;
         default:      len = 8'd0;
      endcase
      return len;
   endfunction

endpackage

// ----- rtl/tcp_option_parser_core.sv -----
// Top level of the TCP options walker: parse state and a four-entry result queue.
// Depends on tcpop_pkg.

// The block takes one options byte per cycle while req_ready is high and walks the
// options in a single pass of logic per byte, writing the zero, one or two results
// that a byte causes into a four-entry result queue. A result is registered in the
// queue when its byte is transferred and reaches the rsp_ channel once the results
// ahead of it are taken. req_ready stays high while at least two queue entries are
// free, so with the result side taking one transfer per cycle a byte is accepted
// every cycle; an area's last byte completing an MSS value or SACK block yields two.
module tcp_option_parser_core
   import tcpop_pkg::*;
#(
   parameter int MAX_AREA_BYTES = 40
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam logic [5:0] MaxLen = 6'(MAX_AREA_BYTES);

   logic [5:0]  byte_offset_ff, byte_offset_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  opt_len_ff, opt_len_in;
   logic [7:0]  bio_ff, bio_in;
   logic [31:0] gather_ff, gather_in;
   logic [31:0] left_ff, left_in;
   logic [2:0]  status_ff, status_in;
   logic [5:0]  latched_len_ff, latched_len_in;
   logic [31:0] latched_base_ff, latched_base_in;

   rsp_payload_type queue_ff [4];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  count_ff;

   logic        accept, pop;
   logic [5:0]  len_sat;
   logic [7:0]  b;
   logic        last;
   phase_type   phase_cur;
   logic [2:0]  status_cur;
   logic [7:0]  expect_len;
   logic        emit_mss, emit_sack;
   rsp_payload_type res0, res1;
   logic [1:0]  n_res;

   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;
   assign b      = req_payload.opt_byte;

   always_comb begin
      if (req_payload.area_len == 6'd0) begin
         len_sat = 6'd1;
      end else if (req_payload.area_len > MaxLen) begin
         len_sat = MaxLen;
      end else begin
         len_sat = req_payload.area_len;
      end
   end

   // Next state of the walker for the byte on the input.
   always_comb begin
      byte_offset_in  = byte_offset_ff;
      kind_in         = kind_ff;
      opt_len_in      = opt_len_ff;
      bio_in          = bio_ff;
      gather_in       = gather_ff;
      left_in         = left_ff;
      latched_len_in  = latched_len_ff;
      latched_base_in = latched_base_ff;
      phase_cur       = phase_ff;
      status_cur      = status_ff;
      expect_len      = fixed_len_of(kind_ff);
      if (byte_offset_ff == 6'd0) begin
         latched_len_in  = len_sat;
         latched_base_in = req_payload.sack_base;
         status_cur      = ST_CONSUMED;
         phase_cur       = PH_KIND;
      end
      last = ({1'b0, byte_offset_ff} + 7'd1) >= {1'b0, latched_len_in};
      phase_in  = phase_cur;
      status_in = status_cur;

      case (phase_cur)
         PH_KIND: begin
            kind_in   = b;
            bio_in    = 8'd0;
            gather_in = 32'd0;
            if (b == KIND_NOP) begin
               phase_in = PH_KIND;
            end else if (b == KIND_EOL) begin
               status_in = ST_EOL;
               phase_in  = PH_STOP;
            end else if (b inside {KIND_MSS, KIND_WSCALE, KIND_SACK_OK,
                                   KIND_SACK, KIND_TSTAMP}) begin
               if (last) begin
                  status_in = ST_NO_LEN;
                  phase_in  = PH_STOP;
               end else begin
                  phase_in = PH_LEN;
               end
            end else begin
               status_in = ST_UNKNOWN;
               phase_in  = PH_STOP;
            end
         end
         PH_LEN: begin
            opt_len_in = b;
            bio_in     = 8'd1;
            if (expect_len != 8'd0 && b != expect_len) begin
               status_in = ST_BAD_FIXED;
               phase_in  = PH_STOP;
            end else if (kind_ff == KIND_SACK && b < 8'd2) begin
               status_in = ST_BAD_SACK;
               phase_in  = PH_STOP;
            end else if (({3'd0, byte_offset_ff} + {1'b0, b}) >
                         ({3'd0, latched_len_in} + 9'd1)) begin
               status_in = ST_OVERRUN;
               phase_in  = PH_STOP;
            end else if (b == 8'd2) begin
               phase_in = PH_KIND;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            bio_in    = bio_ff + 8'd1;
            gather_in = {gather_ff[23:0], b};
            if (kind_ff == KIND_SACK && bio_in == 8'd5) begin
               left_in = gather_in;
            end
            if (({1'b0, bio_in} + 9'd1) >= {1'b0, opt_len_ff}) begin
               phase_in = PH_KIND;
            end
         end
         default: begin
            phase_in = PH_STOP;
         end
      endcase

      if (last) begin
         byte_offset_in = 6'd0;
      end else begin
         byte_offset_in = byte_offset_ff + 6'd1;
      end
   end

   // Results caused by the byte on the input.
   always_comb begin
      emit_mss  = (phase_cur == PH_DATA) && (kind_ff == KIND_MSS) && (bio_in == 8'd3);
      emit_sack = (phase_cur == PH_DATA) && (kind_ff == KIND_SACK) && (bio_in == 8'd9);

      res0 = '0;
      res1 = '0;
      if (emit_mss) begin
         res0.result_kind = RK_MSS;
         res0.mss_value   = gather_in[15:0];
      end else if (emit_sack) begin
         res0.result_kind = RK_SACK;
         res0.sack_left   = left_ff - latched_base_in;
         res0.sack_right  = gather_in - latched_base_in;
      end

      res1.result_kind = RK_END;
      res1.stop_status = (phase_in == PH_STOP) ? status_in : ST_CONSUMED;
      res1.result_last = 1'b1;

      if (emit_mss || emit_sack) begin
         if (last) begin
            n_res = 2'd2;
         end else begin
            n_res            = 2'd1;
            res0.result_last = 1'b1;
         end
      end else if (last) begin
         n_res = 2'd1;
         res0  = res1;
      end else begin
         n_res = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff  <= '0;
         phase_ff        <= PH_KIND;
         kind_ff         <= '0;
         opt_len_ff      <= '0;
         bio_ff          <= '0;
         gather_ff       <= '0;
         left_ff         <= '0;
         status_ff       <= '0;
         latched_len_ff  <= '0;
         latched_base_ff <= '0;
      end else if (accept) begin
         byte_offset_ff  <= byte_offset_in;
         latched_len_ff  <= latched_len_in;
         latched_base_ff <= latched_base_in;
         if (last) begin
            phase_ff  <= PH_KIND;
            kind_ff   <= '0;
            opt_len_ff <= '0;
            bio_ff    <= '0;
            gather_ff <= '0;
            left_ff   <= '0;
            status_ff <= '0;
         end else begin
            phase_ff   <= phase_in;
            kind_ff    <= kind_in;
            opt_len_ff <= opt_len_in;
            bio_ff     <= bio_in;
            gather_ff  <= gather_in;
            left_ff    <= left_in;
            status_ff  <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && n_res != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
         if (n_res == 2'd2) begin
            queue_ff[wr_ptr_ff + 2'd1] <= res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (accept ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
      end
   end

   assign req_ready   = count_ff <= 3'd2;
   assign rsp_valid   = count_ff != 3'd0;
   assign rsp_payload = queue_ff[rd_ptr_ff];

endmodule
